// File: rtl/core/tlc_pkg.sv
// Shared types, constants and helpers for the three-rotor letter cipher.
// Used by tlc_alu, tlc_ram users and the three_rotor_letter_cipher top level.
package tlc_pkg;

  // Alphabet and character constants.
  localparam int unsigned ALPHA = 26;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Rotor and plug board sizes.
  localparam int unsigned NUM_ROTORS = 3;
  localparam int unsigned NUM_PLUGS_DEF = 10;

  // Wiring RAM: four tables of 32 slots each, 26 of them used.
  localparam int unsigned WIRE_SLOTS = 32;
  localparam int unsigned WIRE_DEPTH = 4 * WIRE_SLOTS;
  localparam int unsigned WIRE_AW = $clog2(WIRE_DEPTH);
  localparam logic [1:0] TBL_REFL = 2'd3;
  localparam logic [4:0] LAST_CONTACT = 5'(ALPHA - 1);

  // Configuration register indexes.
  localparam logic REG_NOTCH_FIRST = 1'b0;
  localparam logic REG_NOTCH_SECOND = 1'b1;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_ENCODE      = 2'd0,
    MODE_LOAD_WIRING = 2'd1,
    MODE_LOAD_PLUG   = 2'd2,
    MODE_SET_POS     = 2'd3
  } mode_e;

  // Shared arithmetic unit operations.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLUG,
    ST_FWD_ADDR,
    ST_FWD_DATA,
    ST_REFL_ADDR,
    ST_REFL_DATA,
    ST_BACK_SCAN,
    ST_BACK_LAST,
    ST_BACK_SUB,
    ST_STEP,
    ST_FINISH
  } state_e;

  // Input word.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_in;
    logic [1:0] table_select;
    logic [4:0] slot;
    logic [4:0] entry;
    logic [3:0] plug_slot;
    logic [4:0] plug_first;
    logic [4:0] plug_second;
    logic [1:0] rotor_select;
    logic [4:0] position;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [7:0] char_out;
    logic       error;
  } out_word_t;

  // One plug pair.
  typedef struct packed {
    logic [4:0] first;
    logic [4:0] second;
  } plug_t;

  // Reduces a value below 64 modulo 26.
  function automatic logic [4:0] fold26(input logic [5:0] v);
    logic [5:0] r;
    if (v >= 6'(2 * ALPHA)) begin
      r = v - 6'(2 * ALPHA);
    end else if (v >= 6'(ALPHA)) begin
      r = v - 6'(ALPHA);
    end else begin
      r = v;
    end
    return r[4:0];
  endfunction

endpackage

// File: rtl/core/three_rotor_letter_cipher.sv
// Top level of the three-rotor letter cipher: sequencer, rotor state and plug board.
// Depends on tlc_pkg, tlc_alu and tlc_ram.
//
// Load words (wiring entry, plug pair, rotor position) give no result. A non-letter
// returns an error word. Most of the work of encoding a letter is the three
// reverse-wiring searches, which read the wiring RAM one contact per cycle; each plug
// board pass scans one pair per cycle and stops at the first match, and rotor stepping
// moves one rotor at a time. The block takes one word at a time; a finished result sits
// in an output register, so the next word is accepted while the result waits to be
// taken. Wiring entries that were never loaded read as arbitrary values.
module three_rotor_letter_cipher #(
  parameter int unsigned NUM_PLUGS = tlc_pkg::NUM_PLUGS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlc_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tlc_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [4:0]          cfg_data_i
);

  import tlc_pkg::*;

  localparam int unsigned PIDX_W = (NUM_PLUGS > 1) ? $clog2(NUM_PLUGS) : 1;

  state_e state_q, state_d;

  logic [4:0] notch_first_q, notch_second_q;
  plug_t      plug_q [NUM_PLUGS];
  logic [4:0] pos_q [NUM_ROTORS];

  logic [4:0]        x_q;
  logic              err_q;
  logic              pass2_q;
  logic [PIDX_W-1:0] k_q;
  logic [1:0]        r_q;
  logic [4:0]        j_q;
  logic              rd_vld_q;
  logic [4:0]        rd_idx_q;
  logic              found_q;
  logic [4:0]        hit_q;

  logic      out_valid_q;
  out_word_t out_q;

  // Input decode.
  logic       in_acc;
  mode_e      in_mode;
  logic [7:0] char_up;
  logic       is_letter;

  // Datapath signals.
  alu_op_e            alu_op;
  logic [4:0]         alu_a, alu_b, alu_y;
  logic [WIRE_AW-1:0] ram_raddr;
  logic [4:0]         ram_rdata;
  logic               ram_we;
  logic [4:0]         pos_sel;
  logic [4:0]         notch_sel;
  logic               plug_hit_first, plug_hit_second, plug_last, plug_done;
  logic               scan_match;
  logic               carry;
  logic               out_load;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign in_mode = mode_e'(in_word_i.mode);

  // Case folding and letter check.
  always_comb begin
    if (in_word_i.char_in >= CHAR_LA && in_word_i.char_in <= CHAR_LZ) begin
      char_up = in_word_i.char_in - CASE_OFFSET;
    end else begin
      char_up = in_word_i.char_in;
    end
  end
  assign is_letter = (char_up >= CHAR_A) && (char_up <= CHAR_Z);

  // Status of the plug board scan, the reverse search and stepping.
  assign plug_hit_first  = (x_q == plug_q[k_q].first);
  assign plug_hit_second = (x_q == plug_q[k_q].second);
  assign plug_last       = (k_q == PIDX_W'(NUM_PLUGS - 1));
  assign plug_done       = plug_hit_first || plug_hit_second || plug_last;
  assign scan_match      = rd_vld_q && !found_q && (ram_rdata == x_q);
  assign pos_sel         = pos_q[r_q];
  assign notch_sel       = (r_q == 2'd0) ? notch_first_q : notch_second_q;
  assign carry           = (alu_y == notch_sel) && (r_q < 2'(NUM_ROTORS - 1));
  assign out_load        = !out_valid_q || !out_stall_i;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_mode == MODE_ENCODE) begin
          state_d = is_letter ? ST_PLUG : ST_FINISH;
        end
      end
      ST_PLUG: begin
        if (plug_done) begin
          state_d = pass2_q ? ST_STEP : ST_FWD_ADDR;
        end
      end
      ST_FWD_ADDR:  state_d = ST_FWD_DATA;
      ST_FWD_DATA:  state_d = (r_q == 2'(NUM_ROTORS - 1)) ? ST_REFL_ADDR : ST_FWD_ADDR;
      ST_REFL_ADDR: state_d = ST_REFL_DATA;
      ST_REFL_DATA: state_d = ST_BACK_SCAN;
      ST_BACK_SCAN: begin
        if (j_q == LAST_CONTACT) begin
          state_d = ST_BACK_LAST;
        end
      end
      ST_BACK_LAST: state_d = ST_BACK_SUB;
      ST_BACK_SUB:  state_d = (r_q == 2'd0) ? ST_PLUG : ST_BACK_SCAN;
      ST_STEP: begin
        if (!carry) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer: stall, ALU operands and RAM read address.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    alu_op     = ALU_ADD;
    alu_a      = x_q;
    alu_b      = pos_sel;
    ram_raddr  = {r_q, j_q};
    case (state_q)
      ST_FWD_ADDR: begin
        ram_raddr = {r_q, alu_y};
      end
      ST_REFL_ADDR: begin
        ram_raddr = {TBL_REFL, x_q};
      end
      ST_BACK_SUB: begin
        alu_op = ALU_SUB;
        alu_a  = hit_q;
      end
      ST_STEP: begin
        alu_a = pos_sel;
        alu_b = 5'd1;
      end
      default: begin
        ram_raddr = {r_q, j_q};
      end
    endcase
  end

  // Shared modulo-26 unit.
  tlc_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  // Wiring tables, loaded straight from the input word.
  assign ram_we = in_acc && (in_mode == MODE_LOAD_WIRING) &&
                  (in_word_i.slot < 5'(ALPHA));

  tlc_ram #(
    .WIDTH (5),
    .DEPTH (WIRE_DEPTH)
  ) u_wiring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({in_word_i.table_select, in_word_i.slot}),
    .wdata_i (fold26(6'(in_word_i.entry))),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Notch registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notch_first_q  <= '0;
      notch_second_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_NOTCH_FIRST) begin
        notch_first_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_NOTCH_SECOND) begin
        notch_second_q <= cfg_data_i;
      end
    end
  end

  // Plug board pairs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLUGS; i++) begin
        plug_q[i] <= '0;
      end
    end else if (in_acc && in_mode == MODE_LOAD_PLUG &&
                 32'(in_word_i.plug_slot) < NUM_PLUGS) begin
      plug_q[in_word_i.plug_slot[PIDX_W-1:0]] <= '{
        first:  fold26(6'(in_word_i.plug_first)),
        second: fold26(6'(in_word_i.plug_second))
      };
    end
  end

  // Rotor positions: set by load words, advanced after each letter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ROTORS; i++) begin
        pos_q[i] <= '0;
      end
    end else if (in_acc && in_mode == MODE_SET_POS &&
                 in_word_i.rotor_select < 2'(NUM_ROTORS)) begin
      pos_q[in_word_i.rotor_select] <= fold26(6'(in_word_i.position));
    end else if (state_q == ST_STEP) begin
      pos_q[r_q] <= alu_y;
    end
  end

  // Letter datapath: current letter, counters and reverse search result.
  always_ff @(posedge clk_i) begin
    rd_vld_q <= (state_q == ST_BACK_SCAN);
    rd_idx_q <= j_q;
    if (scan_match) begin
      found_q <= 1'b1;
      hit_q   <= rd_idx_q;
    end
    case (state_q)
      ST_IDLE: begin
        x_q     <= 5'(char_up - CHAR_A);
        err_q   <= !is_letter;
        pass2_q <= 1'b0;
        k_q     <= '0;
      end
      ST_PLUG: begin
        if (plug_hit_first) begin
          x_q <= plug_q[k_q].second;
        end else if (plug_hit_second) begin
          x_q <= plug_q[k_q].first;
        end
        if (plug_done) begin
          r_q <= 2'd0;
        end else begin
          k_q <= k_q + PIDX_W'(1);
        end
      end
      ST_FWD_DATA: begin
        x_q <= ram_rdata;
        r_q <= r_q + 2'd1;
      end
      ST_REFL_DATA: begin
        x_q     <= ram_rdata;
        r_q     <= 2'(NUM_ROTORS - 1);
        j_q     <= '0;
        found_q <= 1'b0;
        hit_q   <= '0;
      end
      ST_BACK_SCAN: begin
        j_q <= j_q + 5'd1;
      end
      ST_BACK_SUB: begin
        x_q     <= alu_y;
        j_q     <= '0;
        found_q <= 1'b0;
        hit_q   <= '0;
        if (r_q == 2'd0) begin
          pass2_q <= 1'b1;
          k_q     <= '0;
        end else begin
          r_q <= r_q - 2'd1;
        end
      end
      ST_STEP: begin
        if (carry) begin
          r_q <= r_q + 2'd1;
        end
      end
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_load) begin
      out_q.char_out <= err_q ? 8'd0 : (8'(x_q) + CHAR_A);
      out_q.error    <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: rtl/core/tlc_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module tlc_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tlc_alu.sv
// Shared modulo-26 add/subtract unit of the letter cipher.
// Depends on tlc_pkg for the operation codes and the fold helper.
module tlc_alu (
  input  tlc_pkg::alu_op_e op_i,
  input  logic [4:0]       a_i,
  input  logic [4:0]       b_i,
  output logic [4:0]       y_o
);

  import tlc_pkg::*;

  logic [5:0] sum;

  // Subtraction adds the complement 26 - b, so the sum stays below 64.
  always_comb begin
    case (op_i)
      ALU_ADD: sum = 6'(a_i) + 6'(b_i);
      ALU_SUB: sum = 6'(a_i) + (6'(ALPHA) - 6'(b_i));
      default: sum = 6'(a_i);
    endcase
  end

  assign y_o = fold26(sum);

endmodule

// File: tb/tlc_checker.sv
// Checker for the three-rotor letter cipher: watches the word channels and the notch writes.
// Predicts each cipher result from its own copy of the tables and compares in order.
// Depends on tlc_pkg for the word types, modes and alphabet constants.
`timescale 1ns / 100ps

module tlc_checker #(
  parameter int unsigned NUM_PLUGS = tlc_pkg::NUM_PLUGS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  tlc_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  tlc_pkg::out_word_t out_word_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  import tlc_pkg::*;

  // Shadow copy of the block state and its notch registers.
  logic [4:0] wiring_q [4][ALPHA];
  plug_t      plug_board [NUM_PLUGS];
  logic [4:0] rotor_pos [NUM_ROTORS];
  logic [4:0] carry_notch0;
  logic [4:0] carry_notch1;
  out_word_t  expected_letters_q [$];

  function automatic logic [4:0] mod_alpha(input int unsigned v);
    return 5'(v % ALPHA);
  endfunction

  // The lowest plug slot that holds the letter decides the swap.
  function automatic logic [4:0] swap_plug(input logic [4:0] x);
    for (int k = 0; k < NUM_PLUGS; k++) begin
      if (x == plug_board[k].first) return plug_board[k].second;
      if (x == plug_board[k].second) return plug_board[k].first;
    end
    return x;
  endfunction

  // Inverse wiring: the lowest matching contact wins, contact 0 when nothing matches.
  function automatic logic [4:0] reverse_rotor(input int r, input logic [4:0] x);
    int unsigned hit;
    logic        found;
    hit = 0;
    found = 1'b0;
    for (int i = 0; i < ALPHA; i++) begin
      if (!found && wiring_q[r][i] == x) begin
        hit = i;
        found = 1'b1;
      end
    end
    return mod_alpha(hit + ALPHA - int'(rotor_pos[r]));
  endfunction

  // Odometer stepping with carries at the notch positions.
  task automatic step_rotors();
    rotor_pos[0] = mod_alpha(int'(rotor_pos[0]) + 1);
    if (rotor_pos[0] == carry_notch0) begin
      rotor_pos[1] = mod_alpha(int'(rotor_pos[1]) + 1);
      if (rotor_pos[1] == carry_notch1) begin
        rotor_pos[2] = mod_alpha(int'(rotor_pos[2]) + 1);
      end
    end
  endtask

  // Applies one accepted word to the shadow state and queues its result, if any.
  task automatic predict_cipher(input in_word_t w);
    logic [7:0] c;
    logic [4:0] x;
    out_word_t  res;
    case (mode_e'(w.mode))
      MODE_LOAD_WIRING: begin
        if (w.slot < ALPHA) wiring_q[w.table_select][w.slot] = mod_alpha(w.entry);
      end
      MODE_LOAD_PLUG: begin
        if (w.plug_slot < NUM_PLUGS) begin
          plug_board[w.plug_slot].first = mod_alpha(w.plug_first);
          plug_board[w.plug_slot].second = mod_alpha(w.plug_second);
        end
      end
      MODE_SET_POS: begin
        if (w.rotor_select < NUM_ROTORS) rotor_pos[w.rotor_select] = mod_alpha(w.position);
      end
      default: begin
        c = w.char_in;
        if (c >= CHAR_LA && c <= CHAR_LZ) c = c - CASE_OFFSET;
        if (c < CHAR_A || c > CHAR_Z) begin
          res.char_out = '0;
          res.error = 1'b1;
        end else begin
          x = 5'(c - CHAR_A);
          x = swap_plug(x);
          for (int r = 0; r < NUM_ROTORS; r++) begin
            x = wiring_q[r][mod_alpha(int'(x) + int'(rotor_pos[r]))];
          end
          x = wiring_q[TBL_REFL][x];
          for (int r = NUM_ROTORS - 1; r >= 0; r--) begin
            x = reverse_rotor(r, x);
          end
          x = swap_plug(x);
          step_rotors();
          res.char_out = CHAR_A + 8'(x);
          res.error = 1'b0;
        end
        expected_letters_q.push_back(res);
      end
    endcase
  endtask

  // Results are checked before the word of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PLUGS; k++) plug_board[k] = '0;
      for (int r = 0; r < NUM_ROTORS; r++) rotor_pos[r] = '0;
      carry_notch0 = '0;
      carry_notch1 = '0;
      expected_letters_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_NOTCH_FIRST) carry_notch0 = cfg_data_i;
        else carry_notch1 = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_letters_q.size() == 0) begin
          $error("char_out: expected no word, actual %h (error %b)",
                 out_word_i.char_out, out_word_i.error);
          fail_count_o++;
        end else begin
          want = expected_letters_q.pop_front();
          if (out_word_i.char_out !== want.char_out) begin
            $error("char_out: expected %h, actual %h", want.char_out, out_word_i.char_out);
            fail_count_o++;
          end
          if (out_word_i.error !== want.error) begin
            $error("error: expected %b, actual %b", want.error, out_word_i.error);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_cipher(in_word_i);
      pending_o = expected_letters_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the cipher testbench: clock, reset, notch programming and word stimulus.
// Instantiates three_rotor_letter_cipher and tlc_checker, which does all the comparing.
// Depends on tlc_pkg.
`timescale 1ns / 100ps

module testbench;
  import tlc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 58;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_data;
  int         fail_count;
  int         pending;
  int         cycle_count;
  int         gap_pct;
  int         stall_pct;
  logic [4:0] notch0_now;
  logic [4:0] notch1_now;

  three_rotor_letter_cipher u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tlc_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run; the count is held at zero during reset and starts once it is released.
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one word after a random gap and returns at the edge that takes it.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_letter(input logic [7:0] c);
    in_word_t w;
    w = '0;
    w.mode = MODE_ENCODE;
    w.char_in = c;
    send_word(w);
  endtask

  task automatic set_wire(input logic [1:0] tbl, input logic [4:0] slot, input logic [4:0] ent);
    in_word_t w;
    w = '0;
    w.mode = MODE_LOAD_WIRING;
    w.table_select = tbl;
    w.slot = slot;
    w.entry = ent;
    send_word(w);
  endtask

  task automatic set_plug(input logic [3:0] ps, input logic [4:0] a, input logic [4:0] b);
    in_word_t w;
    w = '0;
    w.mode = MODE_LOAD_PLUG;
    w.plug_slot = ps;
    w.plug_first = a;
    w.plug_second = b;
    send_word(w);
  endtask

  task automatic set_rotor(input logic [1:0] sel, input logic [4:0] pos);
    in_word_t w;
    w = '0;
    w.mode = MODE_SET_POS;
    w.rotor_select = sel;
    w.position = pos;
    send_word(w);
  endtask

  // Loads one table with a fresh random permutation.
  task automatic load_permutation(input logic [1:0] tbl);
    logic [4:0]  perm [ALPHA];
    logic [4:0]  tmp;
    int unsigned j;
    for (int i = 0; i < ALPHA; i++) perm[i] = 5'(i);
    for (int i = ALPHA - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < ALPHA; i++) set_wire(tbl, 5'(i), perm[i]);
  endtask

  // Position one step before a notch; notches past the alphabet never match anyway.
  function automatic logic [4:0] mod_notch(input logic [4:0] n);
    return 5'((int'(n) + ALPHA - 1) % ALPHA);
  endfunction

  // One random word; mostly letters, with loads mixed in and an occasional carry setup.
  task automatic send_random_word();
    in_word_t    w;
    logic [63:0] raw;
    int unsigned pick;
    int unsigned sel;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 5) begin
      // Park rotors one short of both notches so the next letter carries twice.
      set_rotor(2'd0, mod_notch(notch0_now));
      set_rotor(2'd1, mod_notch(notch1_now));
      w.mode = MODE_ENCODE;
      w.char_in = CHAR_A + 8'($urandom_range(ALPHA - 1));
    end else if (pick < 72) begin
      w.mode = MODE_ENCODE;
      sel = $urandom_range(99);
      if (sel < 45) w.char_in = CHAR_A + 8'($urandom_range(ALPHA - 1));
      else if (sel < 85) w.char_in = CHAR_LA + 8'($urandom_range(ALPHA - 1));
    end else if (pick < 78) begin
      w.mode = MODE_LOAD_WIRING;
    end else if (pick < 88) begin
      w.mode = MODE_LOAD_PLUG;
      if ($urandom_range(9) != 0) w.plug_slot = 4'($urandom_range(NUM_PLUGS_DEF - 1));
    end else begin
      w.mode = MODE_SET_POS;
    end
    send_word(w);
  endtask

  // Writes both notch registers, one per cycle.
  task automatic program_notches(input logic [4:0] n0, input logic [4:0] n1);
    cfg_we <= 1'b1;
    cfg_index <= REG_NOTCH_FIRST;
    cfg_data <= n0;
    @(posedge clk);
    cfg_index <= REG_NOTCH_SECOND;
    cfg_data <= n1;
    @(posedge clk);
    cfg_we <= 1'b0;
    notch0_now = n0;
    notch1_now = n1;
  endtask

  // Stops sending and waits until every result is in and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          gap_tbl [4];
    int          stall_tbl [4];
    logic [4:0]  notch0_tbl [PHASES];
    logic [4:0]  notch1_tbl [PHASES];
    gap_tbl = '{0, 64, 0, 15};
    stall_tbl = '{0, 0, 64, 15};
    notch0_tbl = '{5'd0, 5'd25, 5'd31, 5'd1, 5'd0, 5'd0, 5'd25, 5'd0};
    notch1_tbl = '{5'd0, 5'd25, 5'd31, 5'd2, 5'd0, 5'd0, 5'd0, 5'd31};
    notch0_tbl[4] = 5'($urandom_range(31));
    notch1_tbl[4] = 5'($urandom_range(31));
    notch0_tbl[5] = 5'($urandom_range(31));
    notch1_tbl[5] = 5'($urandom_range(31));

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NOTCH_FIRST;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    notch0_now = '0;
    notch1_now = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every wiring entry is loaded before the first letter is encoded.
    program_notches(notch0_tbl[0], notch1_tbl[0]);
    for (int t = 0; t < 4; t++) load_permutation(2'(t));

    // Character class boundaries and the extreme bytes.
    send_letter(CHAR_A);
    send_letter(CHAR_Z);
    send_letter(CHAR_LA);
    send_letter(CHAR_LZ);
    send_letter(CHAR_A - 8'd1);
    send_letter(CHAR_Z + 8'd1);
    send_letter(CHAR_LA - 8'd1);
    send_letter(CHAR_LZ + 8'd1);
    send_letter(8'h00);
    send_letter(8'hFF);
    // Rotor wrap with carry, an oversize position and an out-of-range rotor select.
    set_rotor(2'd0, 5'd25);
    set_rotor(2'd1, 5'd31);
    set_rotor(2'd3, 5'd7);
    send_letter(CHAR_A + 8'd12);
    // Oversize plug letters, an out-of-range plug slot and overlapping pairs.
    set_plug(4'd0, 5'd31, 5'd26);
    set_plug(4'd15, 5'd1, 5'd2);
    set_plug(4'd9, 5'd3, 5'd5);
    send_letter(CHAR_A + 8'd5);
    send_letter(CHAR_LA);
    // Ignored wiring slot, then a reflector that is no longer a permutation.
    set_wire(2'd0, 5'd31, 5'd4);
    set_wire(TBL_REFL, 5'd0, 5'd31);
    send_letter(CHAR_A + 8'd16);
    load_permutation(TBL_REFL);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        gap_pct = gap_tbl[p % 4];
        stall_pct = stall_tbl[p % 4];
        program_notches(notch0_tbl[p], notch1_tbl[p]);
        load_permutation(2'($urandom_range(3)));
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_random_word();
      settle();
    end

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/tlc_pkg.sv
rtl/core/tlc_ram.sv
rtl/core/tlc_alu.sv
rtl/core/three_rotor_letter_cipher.sv
tb/tlc_checker.sv
tb/testbench.sv
